>>> hdl/first_fit_coalescing_allocator_macros.svh
// Assertion macros used by the allocator sequencer (ffca_ctrl).
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk_i, off during reset
`define FFCA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication
`define FFCA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define FFCA_ASSERT_IMPL(lbl, pre, post, msg)
`define FFCA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> hdl/ffca_pkg.sv
// Types and constants of the first-fit coalescing allocator.
`default_nettype none
package ffca_pkg;

  localparam int MaxEntries = 64;
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam logic [31:0] MaxRequest = 32'hFFFF_FFF0;
  localparam logic [31:0] AlignMask  = 32'hFFFF_FFF0;
  localparam logic [31:0] AlignAdd   = 32'd15;

  // one block descriptor
  typedef struct packed {
    logic        vld;
    logic        used;
    logic [31:0] off;
    logic [31:0] size;
  } ent_t;

  // scan wave passed from cell to cell
  typedef struct packed {
    logic        vld;
    logic        found;
    logic        gt;    // hit block larger than request
    logic        mr;    // right neighbor of hit is free
    logic        ml;    // left neighbor of hit is free
    logic [31:0] off;
  } wave_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_INIT    = 3'd1,
    CMD_SPLIT   = 3'd2,
    CMD_TAKE    = 3'd3,
    CMD_FREE    = 3'd4,
    CMD_MERGE_L = 3'd5
  } cmd_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    cmd_e        cmd;
    logic        alloc;
    logic        mr;
    logic [31:0] key;
    logic [31:0] arena;
  } ctl_t;

endpackage
`default_nettype wire

>>> hdl/ffca_cell.sv
// One descriptor cell of the allocator chain.
`default_nettype none
module ffca_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            first_i,
  input  ffca_pkg::ctl_t  ctl_i,
  input  ffca_pkg::ent_t  left_i,
  input  logic            left_hit_i,
  input  ffca_pkg::ent_t  right_i,
  input  logic            right_hit_i,
  input  ffca_pkg::wave_t wave_i,
  output ffca_pkg::wave_t wave_o,
  output ffca_pkg::ent_t  ent_o,
  output logic            hit_o
);

  ffca_pkg::ent_t  ent_q, ent_d;
  ffca_pkg::wave_t wave_q, wave_d;
  logic            hit_q, hit_d, after_q, after_d;
  logic            match;

  // local compare for the passing scan
  assign match = ent_q.vld && (ctl_i.alloc ? (!ent_q.used && (ent_q.size >= ctl_i.key))
                                           : (ent_q.used && (ent_q.off == ctl_i.key)));

  // wave and marks
  always_comb begin
    wave_d  = wave_i;
    hit_d   = hit_q;
    after_d = after_q;
    if (wave_i.vld) begin
      hit_d   = !wave_i.found && match;
      after_d = wave_i.found;
      if (!wave_i.found && match) begin
        wave_d.found = 1'b1;
        wave_d.off   = ent_q.off;
        wave_d.gt    = ent_q.size > ctl_i.key;
        wave_d.mr    = right_i.vld && !right_i.used;
        wave_d.ml    = left_i.vld && !left_i.used;
      end
    end
  end

  // descriptor update
  always_comb begin
    ent_d = ent_q;
    case (ctl_i.cmd)
      ffca_pkg::CMD_INIT: begin
        ent_d = '0;
        if (first_i) begin
          ent_d.vld  = ctl_i.arena != 32'd0;
          ent_d.size = ctl_i.arena;
        end
      end
      ffca_pkg::CMD_SPLIT: begin
        if (hit_q) begin
          ent_d.size = ctl_i.key;
          ent_d.used = 1'b1;
        end else if (after_q) begin
          if (left_hit_i) begin
            ent_d.vld  = 1'b1;
            ent_d.used = 1'b0;
            ent_d.off  = left_i.off + ctl_i.key;
            ent_d.size = left_i.size - ctl_i.key;
          end else begin
            ent_d = left_i;
          end
        end
      end
      ffca_pkg::CMD_TAKE: begin
        if (hit_q) ent_d.used = 1'b1;
      end
      ffca_pkg::CMD_FREE: begin
        if (hit_q) begin
          ent_d.used = 1'b0;
          if (ctl_i.mr) ent_d.size = ent_q.size + right_i.size;
        end else if (after_q && ctl_i.mr) begin
          ent_d = right_i;
        end
      end
      ffca_pkg::CMD_MERGE_L: begin
        if (right_hit_i) begin
          ent_d.size = ent_q.size + right_i.size;
        end else if (hit_q || after_q) begin
          ent_d = right_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q   <= '0;
      wave_q  <= '0;
      hit_q   <= 1'b0;
      after_q <= 1'b0;
    end else begin
      ent_q   <= ent_d;
      wave_q  <= wave_d;
      hit_q   <= (ctl_i.cmd == ffca_pkg::CMD_INIT) ? 1'b0 : hit_d;
      after_q <= (ctl_i.cmd == ffca_pkg::CMD_INIT) ? 1'b0 : after_d;
    end
  end

  assign wave_o = wave_q;
  assign ent_o  = ent_q;
  assign hit_o  = hit_q;

endmodule
`default_nettype wire

>>> hdl/ffca_ctrl.sv
// Sequencer of the allocator: handshakes, scan launch and table commands.
`default_nettype none
`include "first_fit_coalescing_allocator_macros.svh"
module ffca_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            op_i,
  input  logic [31:0]     request_size_i,
  input  logic [31:0]     release_offset_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [31:0]     block_offset_o,
  output logic            status_o,
  output logic            arena_empty_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [31:0]     cfg_arena_size_i,
  input  ffca_pkg::wave_t tail_i,
  input  logic            any_used_i,
  output ffca_pkg::wave_t head_o,
  output ffca_pkg::ctl_t  ctl_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_ACT   = 5'b00100,
    S_MERGE = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e                    state_q, state_d;
  logic [ffca_pkg::CntW-1:0] cnt_q, cnt_d;
  logic                      op_q, op_d;
  logic [31:0]               key_q, key_d;
  logic                      start_q, start_d;
  ffca_pkg::wave_t           res_q, res_d;
  logic                      out_valid_q, out_valid_d;
  logic [31:0]               out_off_q, out_off_d;
  logic                      out_status_q, out_status_d;
  logic                      out_empty_q, out_empty_d;
  logic                      in_acc, out_acc, cfg_acc, pre_fail, room;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign cfg_acc = cfg_valid_i && (state_q == S_IDLE);
  assign out_acc = out_valid_q && !out_stall_i;
  assign room    = cnt_q < ffca_pkg::CntW'(ffca_pkg::MaxEntries);
  assign pre_fail = !op_i && ((cnt_q == '0) || (request_size_i == 32'd0) ||
                              (request_size_i > ffca_pkg::MaxRequest));

  // sequencing
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    op_d         = op_q;
    key_d        = key_q;
    start_d      = 1'b0;
    res_d        = res_q;
    out_valid_d  = out_acc ? 1'b0 : out_valid_q;
    out_off_d    = out_off_q;
    out_status_d = out_status_q;
    out_empty_d  = out_empty_q;
    ctl_o        = '0;
    ctl_o.alloc  = !op_q;
    ctl_o.key    = key_q;
    ctl_o.mr     = res_q.mr;
    ctl_o.arena  = cfg_arena_size_i;
    case (state_q)
      S_IDLE: begin
        if (cfg_acc) begin
          ctl_o.cmd = ffca_pkg::CMD_INIT;
          cnt_d     = (cfg_arena_size_i != 32'd0) ? ffca_pkg::CntW'(1) : '0;
        end else if (in_acc) begin
          op_d      = op_i;
          key_d     = op_i ? release_offset_i
                           : ((request_size_i + ffca_pkg::AlignAdd) & ffca_pkg::AlignMask);
          res_d     = '0;
          start_d   = !pre_fail;
          state_d   = pre_fail ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail_i.vld) begin
          res_d   = tail_i;
          state_d = tail_i.found ? S_ACT : S_DONE;
        end
      end
      S_ACT: begin
        if (!op_q) begin
          if (res_q.gt && room) begin
            ctl_o.cmd = ffca_pkg::CMD_SPLIT;
            cnt_d     = cnt_q + ffca_pkg::CntW'(1);
          end else begin
            ctl_o.cmd = ffca_pkg::CMD_TAKE;
          end
          state_d = S_DONE;
        end else begin
          ctl_o.cmd = ffca_pkg::CMD_FREE;
          cnt_d     = cnt_q - ffca_pkg::CntW'(res_q.mr);
          state_d   = res_q.ml ? S_MERGE : S_DONE;
        end
      end
      S_MERGE: begin
        ctl_o.cmd = ffca_pkg::CMD_MERGE_L;
        cnt_d     = cnt_q - ffca_pkg::CntW'(1);
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_off_d    = (res_q.found && !op_q) ? res_q.off : 32'd0;
          out_status_d = !res_q.found;
          out_empty_d  = !any_used_i;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    res_q        <= res_d;
    out_off_q    <= out_off_d;
    out_status_q <= out_status_d;
    out_empty_q  <= out_empty_d;
  end

  always_comb begin
    head_o     = '0;
    head_o.vld = start_q;
  end

  // a configuration write wins over a pending input transaction
  assign in_stall_o     = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o    = state_q == S_IDLE;
  assign out_valid_o    = out_valid_q;
  assign block_offset_o = out_off_q;
  assign status_o       = out_status_q;
  assign arena_empty_o  = out_empty_q;

  `FFCA_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_q <= ffca_pkg::CntW'(ffca_pkg::MaxEntries), "descriptor count overflow")
  `FFCA_ASSERT_NEXT(a_busy_after_in, in_acc, in_stall_o, "input taken while busy")
  `FFCA_ASSERT_IMPL(a_fail_zero_off, out_valid_o && status_o, block_offset_o == 32'd0, "failed result carries an offset")
  `FFCA_ASSERT_IMPL(a_split_room, ctl_o.cmd == ffca_pkg::CMD_SPLIT, room, "split with full table")

endmodule
`default_nettype wire

>>> hdl/first_fit_coalescing_allocator.sv
// Top level of the first-fit coalescing allocator: sequencer and cell chain.
// Usage:
//  Input channel (in_valid_i / in_stall_o) carries op_i, request_size_i and
//  release_offset_i; one result per transaction leaves on the output channel
//  (out_valid_o / out_stall_i) with block_offset_o, status_o, arena_empty_o.
//  The block works on one transaction at a time. A scan wave walks the chain
//  of 64 descriptor cells one cell per cycle, then the split or merge is
//  applied; an allocate that fails on its size or on an empty table skips
//  the scan and goes straight to its result.
//  Writing the arena size (cfg_valid_i / cfg_ready_o) is taken only while no
//  transaction is in flight and rebuilds the table.
//  After reset the arena size is zero: every allocate and release fails.
//  A result held by out_stall_i stays stable; the next input transaction is
//  still accepted and worked on, and its result waits until the held one
//  leaves.
`default_nettype none
module first_fit_coalescing_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] request_size_i,
  input  logic [31:0] release_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] block_offset_o,
  output logic        status_o,
  output logic        arena_empty_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_arena_size_i
);

  localparam int N = ffca_pkg::MaxEntries;

  ffca_pkg::ctl_t  ctl;
  ffca_pkg::wave_t wave [N+1];
  ffca_pkg::ent_t  ent  [N];
  logic            hit  [N];
  logic            any_used;

  ffca_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .request_size_i   (request_size_i),
    .release_offset_i (release_offset_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .block_offset_o   (block_offset_o),
    .status_o         (status_o),
    .arena_empty_o    (arena_empty_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_arena_size_i (cfg_arena_size_i),
    .tail_i           (wave[N]),
    .any_used_i       (any_used),
    .head_o           (wave[0]),
    .ctl_o            (ctl)
  );

  // chain of descriptor cells
  for (genvar j = 0; j < N; j++) begin : g_cell
    ffca_pkg::ent_t left_ent, right_ent;
    logic           left_hit, right_hit;
    if (j == 0) begin : g_first
      assign left_ent = '0;
      assign left_hit = 1'b0;
    end else begin : g_mid
      assign left_ent = ent[j-1];
      assign left_hit = hit[j-1];
    end
    if (j == N - 1) begin : g_last
      assign right_ent = '0;
      assign right_hit = 1'b0;
    end else begin : g_inner
      assign right_ent = ent[j+1];
      assign right_hit = hit[j+1];
    end
    ffca_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .first_i     (j == 0),
      .ctl_i       (ctl),
      .left_i      (left_ent),
      .left_hit_i  (left_hit),
      .right_i     (right_ent),
      .right_hit_i (right_hit),
      .wave_i      (wave[j]),
      .wave_o      (wave[j+1]),
      .ent_o       (ent[j]),
      .hit_o       (hit[j])
    );
  end

  // any descriptor in use
  always_comb begin
    any_used = 1'b0;
    for (int j = 0; j < N; j++) begin
      any_used = any_used | (ent[j].vld & ent[j].used);
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_first_fit_coalescing_allocator.sv
// Testbench of the first-fit coalescing allocator: directed and random traffic against a scoreboard model.
`timescale 1ns / 1ps
module tb_first_fit_coalescing_allocator;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_FAIL    = 1'b1;
  localparam int   CYCLE_LIMIT = 2000000;

  // expected result of one transaction
  typedef struct {
    logic [31:0] offset;
    logic        status;
    logic        empty;
  } alloc_res_t;

  typedef struct {
    logic [31:0] off;
    logic [31:0] size;
    logic        used;
  } blk_t;

  // arena model plus queue of pending results
  class arena_scoreboard;
    blk_t        blocks[$];
    alloc_res_t  pending[$];
    int          errors;
    logic [31:0] live[$];

    function void configure(logic [31:0] sz);
      blk_t b;
      blocks.delete();
      live.delete();
      if (sz != 0) begin
        b.off = 0; b.size = sz; b.used = 1'b0;
        blocks.push_back(b);
      end
    endfunction

    function void coalesce();
      int i;
      i = 0;
      while (i + 1 < blocks.size()) begin
        if (!blocks[i].used && !blocks[i+1].used) begin
          blocks[i].size += blocks[i+1].size;
          blocks.delete(i + 1);
        end else begin
          i++;
        end
      end
    endfunction

    // note an accepted input transaction
    function void note_input(logic op, logic [31:0] req, logic [31:0] roff);
      alloc_res_t r;
      logic [31:0] want;
      blk_t nb;
      bit ok;
      ok = 0;
      r.offset = 0;
      if (op == OP_ALLOC) begin
        if (blocks.size() != 0 && req != 0 && req <= 32'hFFFF_FFF0) begin
          want = (req + 32'd15) & ~32'd15;
          foreach (blocks[i]) begin
            if (!ok && !blocks[i].used && blocks[i].size >= want) begin
              r.offset = blocks[i].off;
              if (blocks[i].size > want && blocks.size() < ffca_pkg::MaxEntries) begin
                nb.off = blocks[i].off + want;
                nb.size = blocks[i].size - want;
                nb.used = 1'b0;
                blocks.insert(i + 1, nb);
                blocks[i].size = want;
              end
              blocks[i].used = 1'b1;
              live.push_back(r.offset);
              ok = 1;
            end
          end
        end
      end else begin
        foreach (blocks[i]) begin
          if (!ok && blocks[i].used && blocks[i].off == roff) begin
            blocks[i].used = 1'b0;
            ok = 1;
          end
        end
        if (ok) begin
          foreach (live[k]) if (live[k] == roff) begin live.delete(k); break; end
          coalesce();
        end
      end
      r.status = ok ? ST_OK : ST_FAIL;
      r.empty = 1'b1;
      foreach (blocks[i]) if (blocks[i].used) r.empty = 1'b0;
      pending.push_back(r);
    endfunction

    // compare one output transaction with the oldest expectation
    function void check_result(logic [31:0] offs, logic st, logic emp);
      alloc_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: offset %h status %b", offs, st);
        return;
      end
      e = pending.pop_front();
      if (e.offset !== offs || e.status !== st || e.empty !== emp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp off %h st %b empty %b, got off %h st %b empty %b",
                   e.offset, e.status, e.empty, offs, st, emp);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [31:0] request_size_i = '0;
  logic [31:0] release_offset_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] block_offset_o;
  logic        status_o;
  logic        arena_empty_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_arena_size_i = '0;

  arena_scoreboard sb;
  int  cycles;
  bit  hold_off;

  always #5 clk_i = ~clk_i;

  first_fit_coalescing_allocator DUT (.*);

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result sampling
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(block_offset_o, status_o, arena_empty_o);

  // receiver stall pattern, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_off) out_stall_i <= 1'b1;
    else case ($urandom_range(0, 3))
      0: out_stall_i <= ($urandom_range(0, 1) == 1);
      default: out_stall_i <= 1'b0;
    endcase
  end

  task automatic send(logic op, logic [31:0] req, logic [31:0] roff);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i <= op;
    request_size_i <= req;
    release_offset_i <= roff;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, req, roff);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_arena(logic [31:0] sz);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_arena_size_i <= sz;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.configure(sz);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random allocate/release mix: half allocations, most releases name a live block
  task automatic random_item(int max_sz);
    logic [31:0] roff;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send(OP_ALLOC, (pick < 3) ? $urandom() : $urandom_range(1, max_sz), $urandom());
    end else if (pick < 90 && sb.live.size() != 0) begin
      roff = sb.live[$urandom_range(0, sb.live.size() - 1)];
      send(OP_RELEASE, $urandom(), roff);
    end else begin
      send(OP_RELEASE, $urandom(), (pick < 95) ? $urandom() : $urandom_range(0, 63) * 16);
    end
  endtask

  task automatic random_phase(logic [31:0] sz, int n, int max_sz);
    int gap;
    write_arena(sz);
    for (int i = 0; i < n; i++) begin
      random_item(max_sz);
      if ($urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 40);
        repeat (gap) @(negedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    logic [31:0] keep;
    sb = new();
    cycles = 0;
    hold_off = 0;
    sb.configure(0);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // not configured: both operations fail
    send(OP_ALLOC, 32'd16, 0);
    send(OP_RELEASE, 0, 0);
    drain();

    // directed: extremes, zero size, oversize, no fit, unmatched release
    write_arena(32'd256);
    send(OP_ALLOC, 32'd0, 0);
    send(OP_ALLOC, 32'hFFFF_FFF1, 0);
    send(OP_ALLOC, 32'hFFFF_FFFF, 0);
    send(OP_ALLOC, 32'd1, 0);
    send(OP_ALLOC, 32'd16, 0);
    send(OP_ALLOC, 32'd17, 0);
    send(OP_ALLOC, 32'd4096, 0);
    send(OP_RELEASE, 0, 32'd16);
    send(OP_RELEASE, 0, 32'd16);
    send(OP_RELEASE, 0, 32'hFFFF_FFFF);
    send(OP_RELEASE, 0, 32'd0);
    send(OP_RELEASE, 0, 32'd32);
    drain();
    write_arena(32'hFFFF_FFFF);
    send(OP_ALLOC, 32'hFFFF_FFF0, 0);
    send(OP_ALLOC, 32'd1, 0);
    send(OP_RELEASE, 32'hFFFF_FFFF, 32'd0);
    drain();

    // table full: many small allocations
    random_phase(32'd4096, 120, 40);

    // long receiver hold-off while items keep coming
    write_arena(32'd100000);
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk_i);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) random_item(2000);
    join
    drain();

    random_phase(32'd2048, 250, 300);
    random_phase(32'hFFFF_FFFF, 150, 32'h7FFF_FFFF);
    random_phase(32'd0, 20, 64);
    random_phase(32'd65536, 300, 4000);
    keep = $urandom();
    random_phase(keep, 60, 32'h1000_0000);

    if (sb.errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
